// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the buffer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked only while reset is released.
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rstn, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)

`endif

`endif

// ----- hw/rtl/pqtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqtd_pkg
// Types and constants shared by the per-beam tail-drop buffer modules.
// ----------------------------------------------------------------------------
package pqtd_pkg;

  localparam int BEAM_W    = 4;
  localparam int HANDLE_W  = 16;
  localparam int PBYTES_W  = 16;
  localparam int TIME_W    = 32;
  localparam int BYTES_W   = 30;
  localparam int CNT_W     = 7;
  localparam int TOTAL_W   = 34;
  localparam int NODE_W    = 8;
  localparam int SLOT_W    = 6;
  localparam int MAX_BEAMS = 16;
  localparam int WORD_W    = HANDLE_W + PBYTES_W + TIME_W;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 30'd40000000;

  typedef enum logic [1:0] {
    CMD_ENQ   = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_QUERY = 2'd2
  } pqtd_cmd_e;

  typedef enum logic [2:0] {
    KIND_ACCEPT      = 3'd0,
    KIND_DROP_BYTES  = 3'd1,
    KIND_DROP_FULL   = 3'd2,
    KIND_RELEASED    = 3'd3,
    KIND_FLUSH_EMPTY = 3'd4,
    KIND_STATUS      = 3'd5
  } pqtd_kind_e;

  typedef enum logic {
    CFG_MAX_BYTES = 1'b0,
    CFG_SAT_INDEX = 1'b1
  } pqtd_cfg_e;

  // Classified command handed from the front to the back. For an accepted
  // enqueue, cnt is the slot written; for a non-empty flush, the number of
  // entries to release.
  typedef struct packed {
    pqtd_kind_e          kind;
    logic [BEAM_W-1:0]   beam;
    logic [HANDLE_W-1:0] handle;
    logic [PBYTES_W-1:0] bytes;
    logic [TIME_W-1:0]   now;
    logic [CNT_W-1:0]    cnt;
    logic [BYTES_W-1:0]  beam_bytes;
    logic [CNT_W-1:0]    beam_depth;
    logic [TOTAL_W-1:0]  total;
    logic [NODE_W-1:0]   node;
  } pqtd_rec_t;

  typedef struct packed {
    pqtd_kind_e          kind;
    logic [BEAM_W-1:0]   beam;
    logic [HANDLE_W-1:0] handle;
    logic [PBYTES_W-1:0] bytes;
    logic [TIME_W-1:0]   delay;
    logic                last;
    logic [BYTES_W-1:0]  beam_bytes;
    logic [CNT_W-1:0]    beam_depth;
    logic [TOTAL_W-1:0]  total;
    logic [NODE_W-1:0]   node;
  } pqtd_res_t;

endpackage

// ----- hw/rtl/per_queue_tail_drop_flush_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_queue_tail_drop_flush_buffer
// Per-beam descriptor queues with byte accounting, tail drop and flush.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the input channel (in_valid_i / in_stall_o) and are
//   taken at an edge where valid is high and stall is low. Results leave on
//   the output channel (out_valid_o / out_stall_i) under the same rule.
//   An enqueue, a drop, a query or an empty flush gives one result; a flush
//   of a beam holding n entries gives n results, oldest first, with last
//   set on the final one.
//   Enqueues, drops and queries are taken one per cycle while in_stall_o
//   is low. A flush holds the back end while it releases its entries, one
//   entry-memory read per cycle while the receiver does not stall. A
//   four-deep command queue sits between the classifier and the memory
//   side, so commands keep arriving during a flush until that queue fills.
//   Reset clears all beam counts, byte counts and the total, restores the
//   byte limit to 40000000 and the node id to zero. The entry memory is not
//   cleared; only written entries are ever read.
//   When the receiver stalls, the result register holds its item, the
//   release sequencer pauses, and the command queue fills until in_stall_o
//   rises. The user must write configuration through cfg_we_i only while
//   the block idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------

module per_queue_tail_drop_flush_buffer
  import pqtd_pkg::*;
#(
  parameter int NUM_BEAMS        = 16,
  parameter int ENTRIES_PER_BEAM = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [BYTES_W-1:0]  cfg_data_i,

  // Command channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [BEAM_W-1:0]   beam_i,
  input  logic [HANDLE_W-1:0] packet_handle_i,
  input  logic [PBYTES_W-1:0] packet_bytes_i,
  input  logic [TIME_W-1:0]   now_ms_i,

  // Result channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          kind_o,
  output logic [BEAM_W-1:0]   out_beam_o,
  output logic [HANDLE_W-1:0] out_handle_o,
  output logic [PBYTES_W-1:0] out_bytes_o,
  output logic [TIME_W-1:0]   delay_ms_o,
  output logic                last_o,
  output logic [BYTES_W-1:0]  beam_byte_count_o,
  output logic [CNT_W-1:0]    beam_depth_o,
  output logic [TOTAL_W-1:0]  total_byte_count_o,
  output logic [NODE_W-1:0]   node_id_o
);

  logic [BYTES_W-1:0] max_bytes_q;
  logic [NODE_W-1:0]  node_q;

  logic      q_full;
  logic      q_push;
  pqtd_rec_t q_push_rec;
  logic      q_valid;
  pqtd_rec_t q_pop_rec;
  logic      q_pop;
  pqtd_res_t res;

  // Configuration registers. The index is one bit wide, so every write
  // lands in one of the two registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MAX_BYTES_RESET;
      node_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_BYTES: max_bytes_q <= cfg_data_i;
        CFG_SAT_INDEX: node_q      <= cfg_data_i[NODE_W-1:0];
        default:       node_q      <= node_q;
      endcase
    end
  end

  // The input side stalls only when the command queue is full.
  assign in_stall_o = q_full;

  // Front: accounting and classification, one command per cycle while the command queue is not full.
  pqtd_front #(
    .NUM_BEAMS        (NUM_BEAMS),
    .ENTRIES_PER_BEAM (ENTRIES_PER_BEAM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .q_full_i    (q_full),
    .cmd_i       (cmd_i),
    .beam_i      (beam_i),
    .handle_i    (packet_handle_i),
    .bytes_i     (packet_bytes_i),
    .now_i       (now_ms_i),
    .max_bytes_i (max_bytes_q),
    .node_i      (node_q),
    .push_o      (q_push),
    .rec_o       (q_push_rec)
  );

  pqtd_cmd_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_rec_i (q_push_rec),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_rec_o  (q_pop_rec)
  );

  // Back: entry memory writes, flush release and the result register.
  pqtd_back #(
    .NUM_BEAMS        (NUM_BEAMS),
    .ENTRIES_PER_BEAM (ENTRIES_PER_BEAM)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (q_pop_rec),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o             = res.kind;
  assign out_beam_o         = res.beam;
  assign out_handle_o       = res.handle;
  assign out_bytes_o        = res.bytes;
  assign delay_ms_o         = res.delay;
  assign last_o             = res.last;
  assign beam_byte_count_o  = res.beam_bytes;
  assign beam_depth_o       = res.beam_depth;
  assign total_byte_count_o = res.total;
  assign node_id_o          = res.node;

endmodule

// ----- hw/rtl/pqtd_cmd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqtd_cmd_fifo
// Short queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pqtd_cmd_fifo
  import pqtd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pqtd_rec_t push_rec_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output pqtd_rec_t pop_rec_o
);

  pqtd_rec_t            slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   count_q;

  assign full_o    = (count_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_rec_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_rec_i;
    end
  end

  `ASSERT_CLK(a_count_bound, clk_i, count_q <= Q_CNT_W'(Q_DEPTH), "queue count over depth")
  `ASSERT_RST(a_no_pop_empty, clk_i, rst_ni, pop_i |-> count_q != '0, "pop from empty queue")
  `ASSERT_RST(a_no_push_full, clk_i, rst_ni, push_i |-> (!full_o || pop_i) && !full_o,
              "push into full queue")

endmodule

// ----- hw/rtl/pqtd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqtd_front
// Accepts commands, keeps per-beam accounting and classifies each command.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pqtd_front
  import pqtd_pkg::*;
#(
  parameter int NUM_BEAMS        = 16,
  parameter int ENTRIES_PER_BEAM = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                q_full_i,
  input  logic [1:0]          cmd_i,
  input  logic [BEAM_W-1:0]   beam_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic [PBYTES_W-1:0] bytes_i,
  input  logic [TIME_W-1:0]   now_i,
  input  logic [BYTES_W-1:0]  max_bytes_i,
  input  logic [NODE_W-1:0]   node_i,
  output logic                push_o,
  output pqtd_rec_t           rec_o
);

  localparam int NB_EFF = (NUM_BEAMS < MAX_BEAMS) ? NUM_BEAMS : MAX_BEAMS;
  localparam int BIX_W  = (NB_EFF > 1) ? $clog2(NB_EFF) : 1;
  localparam logic [BEAM_W:0] NB_LIM = (BEAM_W + 1)'(NB_EFF);

  logic [CNT_W-1:0]   cnt_q   [NB_EFF];
  logic [BYTES_W-1:0] bytes_q [NB_EFF];
  logic [TOTAL_W-1:0] total_q;

  logic               accept;
  logic               beam_ok;
  logic [BIX_W-1:0]   idx;
  logic [CNT_W-1:0]   cur_cnt;
  logic [BYTES_W-1:0] cur_bytes;
  logic [BYTES_W:0]   sum;
  logic               over;
  logic               full;
  logic               upd;
  logic [CNT_W-1:0]   cnt_d;
  logic [BYTES_W-1:0] bytes_d;
  logic [TOTAL_W-1:0] total_d;

  assign accept    = in_valid_i && !q_full_i;
  assign beam_ok   = ({1'b0, beam_i} < NB_LIM);
  assign idx       = beam_i[BIX_W-1:0];
  assign cur_cnt   = beam_ok ? cnt_q[idx] : '0;
  assign cur_bytes = beam_ok ? bytes_q[idx] : '0;
  assign sum       = {1'b0, cur_bytes} + (BYTES_W + 1)'(bytes_i);
  assign over      = (sum > {1'b0, max_bytes_i});
  assign full      = (cur_cnt >= CNT_W'(ENTRIES_PER_BEAM));

  always_comb begin
    push_o           = accept;
    upd              = 1'b0;
    cnt_d            = cur_cnt;
    bytes_d          = cur_bytes;
    total_d          = total_q;
    rec_o.kind       = KIND_STATUS;
    rec_o.beam       = beam_i;
    rec_o.handle     = '0;
    rec_o.bytes      = '0;
    rec_o.now        = now_i;
    rec_o.cnt        = cur_cnt;
    rec_o.node       = node_i;
    case (cmd_i)
      CMD_ENQ: begin
        rec_o.handle = handle_i;
        rec_o.bytes  = bytes_i;
        if (!beam_ok) begin
          rec_o.kind = KIND_DROP_FULL;
        end else if (over) begin
          rec_o.kind = KIND_DROP_BYTES;
        end else if (full) begin
          rec_o.kind = KIND_DROP_FULL;
        end else begin
          rec_o.kind = KIND_ACCEPT;
          upd        = 1'b1;
          cnt_d      = cur_cnt + 1'b1;
          bytes_d    = sum[BYTES_W-1:0];
          total_d    = total_q + TOTAL_W'(bytes_i);
        end
      end
      CMD_FLUSH: begin
        if (!beam_ok || cur_cnt == '0) begin
          rec_o.kind = KIND_FLUSH_EMPTY;
        end else begin
          rec_o.kind = KIND_RELEASED;
          upd        = 1'b1;
          cnt_d      = '0;
          bytes_d    = '0;
          total_d    = total_q - TOTAL_W'(cur_bytes);
        end
      end
      CMD_QUERY: begin
        rec_o.kind = KIND_STATUS;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
    rec_o.beam_bytes = bytes_d;
    rec_o.beam_depth = cnt_d;
    rec_o.total      = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NB_EFF; i++) begin
        cnt_q[i]   <= '0;
        bytes_q[i] <= '0;
      end
      total_q <= '0;
    end else if (accept && upd) begin
      cnt_q[idx]   <= cnt_d;
      bytes_q[idx] <= bytes_d;
      total_q      <= total_d;
    end
  end

  `ASSERT_RST(a_depth_bound, clk_i, rst_ni, cur_cnt <= CNT_W'(ENTRIES_PER_BEAM),
              "beam depth over capacity")

endmodule

// ----- hw/rtl/pqtd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqtd_back
// Holds the entry memory, writes accepted descriptors and releases flushes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pqtd_back
  import pqtd_pkg::*;
#(
  parameter int NUM_BEAMS        = 16,
  parameter int ENTRIES_PER_BEAM = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  pqtd_rec_t q_rec_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output pqtd_res_t res_o
);

  localparam int NB_EFF = (NUM_BEAMS < MAX_BEAMS) ? NUM_BEAMS : MAX_BEAMS;
  localparam int DEPTH  = NB_EFF * ENTRIES_PER_BEAM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    S_IDLE,
    S_FLUSH
  } state_e;

  logic [WORD_W-1:0] mem [DEPTH];

  state_e            state_q;
  pqtd_rec_t         cur_q;
  logic [CNT_W-1:0]  rd_cnt_q;
  logic              rd_valid_q;
  logic              rd_last_q;
  logic [WORD_W-1:0] rdata_q;
  logic              out_valid_q;
  pqtd_res_t         out_q;

  logic              out_free;
  logic              move;
  logic              issue;
  logic              take;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  assign out_free = !out_valid_q || !out_stall_i;
  assign move     = rd_valid_q && out_free;
  assign take     = (state_q == S_IDLE) && q_valid_i && out_free;
  assign pop_o    = take;
  assign wr_en    = take && (q_rec_i.kind == KIND_ACCEPT);
  assign issue    = (state_q == S_FLUSH) && (rd_cnt_q < cur_q.cnt) &&
                    (!rd_valid_q || move);

  assign wr_addr = ADDR_W'(int'(q_rec_i.beam) * ENTRIES_PER_BEAM +
                           int'(q_rec_i.cnt[SLOT_W-1:0]));
  assign rd_addr = ADDR_W'(int'(cur_q.beam) * ENTRIES_PER_BEAM +
                           int'(rd_cnt_q[SLOT_W-1:0]));

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take && q_rec_i.kind != KIND_RELEASED) begin
        out_valid_q <= 1'b1;
      end else if (move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (issue) begin
        rd_valid_q <= 1'b1;
      end else if (move) begin
        rd_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (take && q_rec_i.kind == KIND_RELEASED) begin
            state_q  <= S_FLUSH;
            rd_cnt_q <= '0;
          end
        end
        S_FLUSH: begin
          if (issue) begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
          if (move && rd_last_q) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= q_rec_i;
    end
    if (issue) begin
      rd_last_q <= ((rd_cnt_q + 1'b1) == cur_q.cnt);
    end
    if (take && q_rec_i.kind != KIND_RELEASED) begin
      out_q.kind       <= q_rec_i.kind;
      out_q.beam       <= q_rec_i.beam;
      out_q.handle     <= q_rec_i.handle;
      out_q.bytes      <= q_rec_i.bytes;
      out_q.delay      <= '0;
      out_q.last       <= 1'b1;
      out_q.beam_bytes <= q_rec_i.beam_bytes;
      out_q.beam_depth <= q_rec_i.beam_depth;
      out_q.total      <= q_rec_i.total;
      out_q.node       <= q_rec_i.node;
    end else if (move) begin
      out_q.kind       <= KIND_RELEASED;
      out_q.beam       <= cur_q.beam;
      out_q.handle     <= rdata_q[WORD_W-1 -: HANDLE_W];
      out_q.bytes      <= rdata_q[TIME_W +: PBYTES_W];
      out_q.delay      <= cur_q.now - rdata_q[TIME_W-1:0];
      out_q.last       <= rd_last_q;
      out_q.beam_bytes <= cur_q.beam_bytes;
      out_q.beam_depth <= cur_q.beam_depth;
      out_q.total      <= cur_q.total;
      out_q.node       <= cur_q.node;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {q_rec_i.handle, q_rec_i.bytes, q_rec_i.now};
    end
    if (issue) begin
      rdata_q <= mem[rd_addr];
    end
  end

  `ASSERT_RST(a_read_in_flush, clk_i, rst_ni, rd_valid_q |-> state_q == S_FLUSH,
              "entry read pending outside a flush")
  `ASSERT_RST(a_flush_ends_last, clk_i, rst_ni,
              (state_q == S_FLUSH) ##1 (state_q == S_IDLE) |-> out_valid_q && out_q.last,
              "flush ended without a final release")

endmodule

// ----- test/tb_per_queue_tail_drop_flush_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_queue_tail_drop_flush_buffer
// Self-checking bench for the per-beam tail-drop descriptor buffer. A short
// directed plan covers reset state, field extremes, both drop reasons, the
// zero-size packet at the byte limit, a full-depth flush and the unused
// command code. Random traffic then runs in three phases with different
// handshake pressure and register settings. Every result is checked field
// by field against its typed-in value or a cycle-free bench queue model.
// ----------------------------------------------------------------------------

module tb_per_queue_tail_drop_flush_buffer;
  import pqtd_pkg::*;

  localparam int          SLOTS      = 64;
  localparam int          RUN_LIMIT  = 1000000;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  // One line of the directed plan: either a register write or a command,
  // optionally repeated, optionally with its single result typed in.
  typedef struct packed {
    bit                  is_cfg;
    pqtd_cfg_e           reg_sel;
    logic [BYTES_W-1:0]  reg_val;
    logic [1:0]          cmd;
    logic [BEAM_W-1:0]   beam;
    logic [HANDLE_W-1:0] handle;
    logic [PBYTES_W-1:0] size;
    logic [TIME_W-1:0]   now;
    logic [CNT_W-1:0]    reps;
    bit                  lit;
    pqtd_kind_e          kind;
    logic [BYTES_W-1:0]  bb;
    logic [CNT_W-1:0]    dep;
    logic [TOTAL_W-1:0]  tot;
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  pqtd_cfg_e           cfg_idx;
  logic [BYTES_W-1:0]  cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          cmd;
  logic [BEAM_W-1:0]   beam;
  logic [HANDLE_W-1:0] pkt_handle;
  logic [PBYTES_W-1:0] pkt_bytes;
  logic [TIME_W-1:0]   now_ms;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          kind;
  logic [BEAM_W-1:0]   out_beam;
  logic [HANDLE_W-1:0] out_handle;
  logic [PBYTES_W-1:0] out_bytes;
  logic [TIME_W-1:0]   delay_ms;
  logic                last;
  logic [BYTES_W-1:0]  beam_byte_count;
  logic [CNT_W-1:0]    beam_depth;
  logic [TOTAL_W-1:0]  total_byte_count;
  logic [NODE_W-1:0]   node_id;

  // Bench copy of the queue state and registers.
  logic [WORD_W-1:0]   slot_mem      [MAX_BEAMS][SLOTS];
  logic [CNT_W-1:0]    depth_held    [MAX_BEAMS];
  logic [BYTES_W-1:0]  bytes_held    [MAX_BEAMS];
  logic [TOTAL_W-1:0]  total_held;
  logic [BYTES_W-1:0]  byte_limit;
  logic [NODE_W-1:0]   node_shadow;

  pqtd_res_t           pending_res [$];
  plan_row_t           plan [$];
  int                  errors = 0;
  int                  cycles = 0;
  int                  snd_idle_pct;
  int                  rcv_idle_pct;
  logic [TIME_W-1:0]   wall_ms;

  per_queue_tail_drop_flush_buffer u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .cmd_i              (cmd),
    .beam_i             (beam),
    .packet_handle_i    (pkt_handle),
    .packet_bytes_i     (pkt_bytes),
    .now_ms_i           (now_ms),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .kind_o             (kind),
    .out_beam_o         (out_beam),
    .out_handle_o       (out_handle),
    .out_bytes_o        (out_bytes),
    .delay_ms_o         (delay_ms),
    .last_o             (last),
    .beam_byte_count_o  (beam_byte_count),
    .beam_depth_o       (beam_depth),
    .total_byte_count_o (total_byte_count),
    .node_id_o          (node_id)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run guard: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("** per_queue_tail_drop_flush_buffer: FAILED **");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Queue model
  // ---------------------------------------------------------------------------

  task automatic clear_queues();
    for (int b = 0; b < MAX_BEAMS; b++) begin
      depth_held[b] = '0;
      bytes_held[b] = '0;
    end
    total_held  = '0;
    byte_limit  = MAX_BYTES_RESET;
    node_shadow = '0;
  endtask

  // Applies one accepted command to the queue copy and, when keep is set,
  // queues the results it must produce.
  task automatic predict_cmd(input logic [1:0] c, input logic [BEAM_W-1:0] b,
                             input logic [HANDLE_W-1:0] h,
                             input logic [PBYTES_W-1:0] sz,
                             input logic [TIME_W-1:0] t, input bit keep);
    pqtd_res_t         r;
    logic [WORD_W-1:0] word;
    int                n;
    bit                single;
    r      = '0;
    r.beam = b;
    r.last = 1'b1;
    r.node = node_shadow;
    single = 1'b1;
    case (c)
      CMD_ENQ: begin
        r.handle = h;
        r.bytes  = sz;
        // The byte limit is tested before the store depth.
        if ({2'b00, bytes_held[b]} + {16'h0000, sz} > {2'b00, byte_limit}) begin
          r.kind = KIND_DROP_BYTES;
        end else if (depth_held[b] >= SLOTS) begin
          r.kind = KIND_DROP_FULL;
        end else begin
          slot_mem[b][depth_held[b][SLOT_W-1:0]] = {h, sz, t};
          depth_held[b] = depth_held[b] + 1'b1;
          bytes_held[b] = bytes_held[b] + sz;
          total_held    = total_held + sz;
          r.kind        = KIND_ACCEPT;
        end
      end
      CMD_FLUSH: begin
        if (depth_held[b] == 0) begin
          r.kind = KIND_FLUSH_EMPTY;
        end else begin
          // Accounting in every release already shows the emptied beam.
          single        = 1'b0;
          n             = int'(depth_held[b]);
          total_held    = total_held - bytes_held[b];
          depth_held[b] = '0;
          bytes_held[b] = '0;
          for (int i = 0; i < n; i++) begin
            word         = slot_mem[b][i];
            r.kind       = KIND_RELEASED;
            r.handle     = word[63:48];
            r.bytes      = word[47:32];
            r.delay      = t - word[31:0];
            r.last       = (i == n - 1);
            r.beam_bytes = '0;
            r.beam_depth = '0;
            r.total      = total_held;
            if (keep) pending_res = {pending_res, r};
          end
        end
      end
      CMD_QUERY: r.kind = KIND_STATUS;
      default:   single = 1'b0;    // unused code: no result, no change
    endcase
    if (single) begin
      r.beam_bytes = bytes_held[b];
      r.beam_depth = depth_held[b];
      r.total      = total_held;
      if (keep) pending_res = {pending_res, r};
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic cmp_field(input string fname, input logic [63:0] want,
                           input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input pqtd_res_t got);
    pqtd_res_t want;
    if (pending_res.size() == 0) begin
      $display("%0t: unexpected result: expected none, got kind %0d beam %0d handle %0d",
               $time, got.kind, got.beam, got.handle);
      errors++;
    end else begin
      want = pending_res.pop_front();
      cmp_field("kind",             64'(want.kind),       64'(got.kind));
      cmp_field("out_beam",         64'(want.beam),       64'(got.beam));
      cmp_field("out_handle",       64'(want.handle),     64'(got.handle));
      cmp_field("out_bytes",        64'(want.bytes),      64'(got.bytes));
      cmp_field("delay_ms",         64'(want.delay),      64'(got.delay));
      cmp_field("last",             64'(want.last),       64'(got.last));
      cmp_field("beam_byte_count",  64'(want.beam_bytes), 64'(got.beam_bytes));
      cmp_field("beam_depth",       64'(want.beam_depth), 64'(got.beam_depth));
      cmp_field("total_byte_count", 64'(want.total),      64'(got.total));
      cmp_field("node_id",          64'(want.node),       64'(got.node));
    end
  endtask

  // Inputs settle after each rising edge, so the falling edge sees the values
  // that decide the next acceptance.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && !out_stall) begin
      check_result({kind, out_beam, out_handle, out_bytes, delay_ms, last,
                    beam_byte_count, beam_depth, total_byte_count, node_id});
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Called at a rising edge; returns at the edge that took the item, with
  // valid still high so that the next item can follow back to back.
  task automatic send_cmd(input logic [1:0] c, input logic [BEAM_W-1:0] b,
                          input logic [HANDLE_W-1:0] h,
                          input logic [PBYTES_W-1:0] sz,
                          input logic [TIME_W-1:0] t, input bit keep);
    int gap;
    bit taken;
    gap = 0;
    while ($urandom_range(0, 99) < snd_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    beam       <= b;
    pkt_handle <= h;
    pkt_bytes  <= sz;
    now_ms     <= t;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end
    predict_cmd(c, b, h, sz, t, keep);
  endtask

  // Drops valid and waits until every queued result has been seen, then keeps
  // idling in case the last command was one that gives no result.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input pqtd_cfg_e sel, input logic [BYTES_W-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= sel;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (sel == CFG_MAX_BYTES) byte_limit = val;
    else node_shadow = val[NODE_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Directed plan
  // ---------------------------------------------------------------------------

  function automatic plan_row_t cmd_row(input logic [1:0] c, input int b,
                                        input int h, input int sz,
                                        input logic [TIME_W-1:0] t, input int n);
    plan_row_t p;
    p        = '0;
    p.cmd    = c;
    p.beam   = BEAM_W'(b);
    p.handle = HANDLE_W'(h);
    p.size   = PBYTES_W'(sz);
    p.now    = t;
    p.reps   = CNT_W'(n);
    return p;
  endfunction

  function automatic plan_row_t lit_row(input plan_row_t p, input pqtd_kind_e k,
                                        input int bb, input int dep,
                                        input int tot);
    p.lit  = 1'b1;
    p.kind = k;
    p.bb   = BYTES_W'(bb);
    p.dep  = CNT_W'(dep);
    p.tot  = TOTAL_W'(tot);
    return p;
  endfunction

  function automatic plan_row_t cfg_row(input pqtd_cfg_e sel,
                                        input logic [BYTES_W-1:0] val);
    plan_row_t p;
    p         = '0;
    p.is_cfg  = 1'b1;
    p.reg_sel = sel;
    p.reg_val = val;
    return p;
  endfunction

  task automatic add_row(input plan_row_t p);
    plan = {plan, p};
  endtask

  task automatic build_plan();
    // Reset state: every beam empty, node id zero.
    add_row(lit_row(cmd_row(CMD_QUERY, 0, 0, 0, 0, 1), KIND_STATUS, 0, 0, 0));
    add_row(lit_row(cmd_row(CMD_QUERY, 15, 0, 0, 0, 1), KIND_STATUS, 0, 0, 0));
    add_row(lit_row(cmd_row(CMD_FLUSH, 3, 0, 0, 0, 1), KIND_FLUSH_EMPTY, 0, 0, 0));
    // Field extremes, all ones then all zeros.
    add_row(lit_row(cmd_row(CMD_ENQ, 0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1),
                    KIND_ACCEPT, 65535, 1, 65535));
    add_row(lit_row(cmd_row(CMD_ENQ, 0, 0, 0, 0, 1), KIND_ACCEPT, 65535, 2, 65535));
    add_row(cmd_row(CMD_ENQ, 15, 16'h5A5A, 16'h00FF, 32'h8000_0000, 1));
    add_row(cmd_row(CMD_UNUSED, 5, 16'h1111, 16'h2222, 32'h3333_3333, 1));
    add_row(cmd_row(CMD_QUERY, 0, 0, 0, 0, 1));
    // Delays that wrap around the 32-bit time, the second to all ones.
    add_row(cmd_row(CMD_FLUSH, 0, 0, 0, 32'd10, 1));
    add_row(cmd_row(CMD_FLUSH, 15, 0, 0, 32'h7FFF_FFFF, 1));
    add_row(lit_row(cmd_row(CMD_FLUSH, 0, 0, 0, 0, 1), KIND_FLUSH_EMPTY, 0, 0, 0));
    // Lowest byte limit, top node id. Beam 2 is filled to exactly the limit.
    add_row(cfg_row(CFG_MAX_BYTES, 30'd1000000));
    add_row(cfg_row(CFG_SAT_INDEX, 30'd255));
    add_row(cmd_row(CMD_ENQ, 2, 16'hA5A0, 16'hFFFF, 32'd100, 15));
    add_row(cmd_row(CMD_ENQ, 2, 16'h0F0F, 16975, 32'd200, 1));
    add_row(lit_row(cmd_row(CMD_ENQ, 2, 16'h1234, 1, 32'd210, 1),
                    KIND_DROP_BYTES, 1000000, 16, 1000000));
    // Zero-size packets still fit at the limit until the store is full.
    add_row(cmd_row(CMD_ENQ, 2, 16'h4000, 0, 32'd220, 48));
    add_row(lit_row(cmd_row(CMD_ENQ, 2, 16'h5678, 0, 32'd230, 1),
                    KIND_DROP_FULL, 1000000, 64, 1000000));
    // A full store still reports the byte drop first.
    add_row(lit_row(cmd_row(CMD_ENQ, 2, 16'h9ABC, 1, 32'd240, 1),
                    KIND_DROP_BYTES, 1000000, 64, 1000000));
    add_row(cmd_row(CMD_FLUSH, 2, 0, 0, 32'd300, 1));
    add_row(lit_row(cmd_row(CMD_QUERY, 2, 0, 0, 0, 1), KIND_STATUS, 0, 0, 0));
  endtask

  task automatic walk_plan();
    plan_row_t p;
    pqtd_res_t r;
    for (int i = 0; i < plan.size(); i++) begin
      p = plan[i];
      if (p.is_cfg) begin
        quiesce();
        write_reg(p.reg_sel, p.reg_val);
      end else if (p.lit) begin
        // Typed-in rows give one result; the model still tracks the state.
        send_cmd(p.cmd, p.beam, p.handle, p.size, p.now, 1'b0);
        r            = '0;
        r.kind       = p.kind;
        r.beam       = p.beam;
        r.last       = 1'b1;
        r.beam_bytes = p.bb;
        r.beam_depth = p.dep;
        r.total      = p.tot;
        r.node       = node_shadow;
        if (p.kind != KIND_STATUS && p.kind != KIND_FLUSH_EMPTY) begin
          r.handle = p.handle;
          r.bytes  = p.size;
        end
        pending_res = {pending_res, r};
      end else begin
        for (int k = 0; k < p.reps; k++) begin
          send_cmd(p.cmd, p.beam, HANDLE_W'(int'(p.handle) + k), p.size, p.now, 1'b1);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic
  // ---------------------------------------------------------------------------

  // Mostly steady time with small steps, now and then a jump anywhere.
  function automatic logic [TIME_W-1:0] next_ms();
    if ($urandom_range(0, 15) == 0) wall_ms = $urandom();
    else wall_ms = wall_ms + $urandom_range(0, 2000);
    return wall_ms;
  endfunction

  function automatic logic [PBYTES_W-1:0] draw_size(input int mode);
    case (mode)
      0:       return '0;
      1:       return PBYTES_W'($urandom_range(0, 255));
      default: return PBYTES_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Bursts of enqueues to one beam, usually closed by a flush, make up most
  // of the traffic so that beams reach the byte limit and the full store.
  // The rest is single commands of any kind to any beam.
  task automatic run_traffic(input int target);
    int                sent;
    int                sel;
    int                n;
    int                mode;
    logic [1:0]        c;
    logic [BEAM_W-1:0] b;
    sent = 0;
    while (sent < target) begin
      sel = $urandom_range(0, 9);
      b   = ($urandom_range(0, 3) == 0) ? BEAM_W'($urandom_range(0, 15)) :
                                          BEAM_W'($urandom_range(0, 3));
      if (sel < 5) begin
        n    = $urandom_range(1, 70);
        mode = $urandom_range(0, 2);
        repeat (n) begin
          send_cmd(CMD_ENQ, b, HANDLE_W'($urandom_range(0, 65535)), draw_size(mode),
                   next_ms(), 1'b1);
          sent++;
        end
        if ($urandom_range(0, 9) < 7) begin
          send_cmd(CMD_FLUSH, b, HANDLE_W'($urandom_range(0, 65535)),
                   PBYTES_W'($urandom_range(0, 65535)), next_ms(), 1'b1);
          sent++;
        end
      end else begin
        if (sel < 8) c = ($urandom_range(0, 7) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
        else c = ($urandom_range(0, 1) == 0) ? CMD_QUERY : CMD_FLUSH;
        send_cmd(c, b, HANDLE_W'($urandom_range(0, 65535)), draw_size($urandom_range(0, 2)),
                 next_ms(), 1'b1);
        if (c != CMD_UNUSED) sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    wall_ms      = $urandom();
    snd_idle_pct = 19;
    rcv_idle_pct = 57;
    clear_queues();
    rst_ni     <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_MAX_BYTES;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    cmd        <= CMD_ENQ;
    beam       <= '0;
    pkt_handle <= '0;
    pkt_bytes  <= '0;
    now_ms     <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    build_plan();
    walk_plan();

    // Phase 1: eager sender, often-stalling receiver, a limit low enough to drop.
    quiesce();
    write_reg(CFG_MAX_BYTES, BYTES_W'($urandom_range(1000000, 3000000)));
    write_reg(CFG_SAT_INDEX, BYTES_W'($urandom_range(0, 30'h3FFF_FFFF)));
    run_traffic(130);

    // Phase 2: roles swapped, lowest limit, id written with all data bits set.
    quiesce();
    snd_idle_pct = 57;
    rcv_idle_pct = 19;
    write_reg(CFG_MAX_BYTES, 30'd1000000);
    write_reg(CFG_SAT_INDEX, 30'h3FFF_FFFF);
    run_traffic(130);

    // Phase 3: no idling on either side, limit anywhere from 1000000 to 1000000000.
    quiesce();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_reg(CFG_MAX_BYTES, BYTES_W'($urandom_range(1000000, 1000000000)));
    write_reg(CFG_SAT_INDEX, BYTES_W'($urandom_range(0, 255)));
    run_traffic(130);

    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (errors == 0) begin
      $display("** per_queue_tail_drop_flush_buffer: PASSED **");
    end else begin
      $display("** per_queue_tail_drop_flush_buffer: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pqtd_pkg.sv
hw/rtl/pqtd_cmd_fifo.sv
hw/rtl/pqtd_front.sv
hw/rtl/pqtd_back.sv
hw/rtl/per_queue_tail_drop_flush_buffer.sv
test/tb_per_queue_tail_drop_flush_buffer.sv
